[design/csvp_pkg.sv]
// Shared types, codes and constants of the CSV record field parser.
// Used by the controller, the datapath and the top level.
package csvp_pkg;

  localparam int unsigned FieldCountDefault = 8;
  localparam int unsigned TextFieldsDefault = 4;
  localparam int unsigned TextLimitDefault  = 49;

  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_QUOTE  = 8'd34;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_COMMA  = 8'd44;
  localparam logic [7:0] CH_MINUS  = 8'd45;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_COLON  = 8'd58;

  localparam logic [6:0]  LEN_MAX   = 7'd127;
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] EMPTY_NUM = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_TEXT      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_REC_END   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic {
    ST_RUN   = 1'b0,
    ST_FLUSH = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]   kind;
    logic [2:0]   field_number;
    logic [7:0]   text_char;
    logic [31:0]  number;
    logic         field_empty;
    logic         text_truncated;
    logic         last;
  } result_t;

  typedef struct packed {
    logic take_byte;
    logic emit_end;
    logic emit_rec;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_term;
    logic fields_done;
  } stat_t;

endpackage

[design/csvp_byte_if.sv]
// Input channel: one record byte per transfer, valid/ready handshake.
// Depends on nothing.
interface csvp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

[design/csvp_result_if.sv]
// Output channel: one parse result per transfer, valid/ready handshake.
// Depends on nothing.
interface csvp_result_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic        [2:0]  field_number;
  logic        [7:0]  text_char;
  logic signed [31:0] number;
  logic               field_empty;
  logic               text_truncated;
  logic               last;

  modport source (output valid, output kind, output field_number, output text_char,
                  output number, output field_empty, output text_truncated,
                  output last, input ready);
  modport sink (input valid, input kind, input field_number, input text_char,
                input number, input field_empty, input text_truncated,
                input last, output ready);
endinterface

[design/csv_record_field_parser_top.sv]
// CSV record field parser, top level. Each result is held in the single result register before it is presented.
// Throughput: one byte per cycle inside fields, limited by the single result register.
// After a record terminator is taken, the controller's flush state issues one field end per
// remaining field and then the record end.
// Reset (rst_ni, async, active low) clears quoting, field and number state and the result valid flag.
// Depends on csvp_pkg, csvp_byte_if, csvp_result_if, csvp_ctrl and csvp_dp.
module csv_record_field_parser_top
  import csvp_pkg::*;
#(
  parameter int unsigned FIELD_COUNT = FieldCountDefault,
  parameter int unsigned TEXT_FIELDS = TextFieldsDefault,
  parameter int unsigned TEXT_LIMIT  = TextLimitDefault
) (
  input logic           clk_i,
  input logic           rst_ni,
  csvp_byte_if.sink     byte_i,
  csvp_result_if.source result_o
);

  cmd_t    cmd;
  stat_t   stat;
  result_t res;

  csvp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .stat_i     (stat),
    .in_ready_o (byte_i.ready),
    .cmd_o      (cmd)
  );

  csvp_dp #(
    .FIELD_COUNT (FIELD_COUNT),
    .TEXT_FIELDS (TEXT_FIELDS),
    .TEXT_LIMIT  (TEXT_LIMIT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (byte_i.in_byte),
    .cmd_i       (cmd),
    .out_ready_i (result_o.ready),
    .stat_o      (stat),
    .out_valid_o (result_o.valid),
    .out_o       (res)
  );

  assign result_o.kind           = res.kind;
  assign result_o.field_number   = res.field_number;
  assign result_o.text_char      = res.text_char;
  assign result_o.number         = signed'(res.number);
  assign result_o.field_empty    = res.field_empty;
  assign result_o.text_truncated = res.text_truncated;
  assign result_o.last           = res.last;

endmodule

[design/csvp_ctrl.sv]
// Controller: takes bytes and sequences the field-end flush at record end.
// Depends on csvp_pkg.
module csvp_ctrl
  import csvp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output logic  in_ready_o,
  output cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (in_valid_i && stat_i.out_free && stat_i.is_term) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (stat_i.out_free && stat_i.fields_done) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_RUN: begin
        in_ready_o      = stat_i.out_free;
        cmd_o.take_byte = in_valid_i && stat_i.out_free;
      end
      ST_FLUSH: begin
        cmd_o.emit_end = stat_i.out_free && !stat_i.fields_done;
        cmd_o.emit_rec = stat_i.out_free && stat_i.fields_done;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/csvp_dp.sv]
// Datapath: field state, number conversion and the result register.
// Depends on csvp_pkg; driven by csvp_ctrl commands.
module csvp_dp
  import csvp_pkg::*;
#(
  parameter int unsigned FIELD_COUNT = FieldCountDefault,
  parameter int unsigned TEXT_FIELDS = TextFieldsDefault,
  parameter int unsigned TEXT_LIMIT  = TextLimitDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] in_byte_i,
  input  cmd_t       cmd_i,
  input  logic       out_ready_i,
  output stat_t      stat_o,
  output logic       out_valid_o,
  output result_t    out_o
);

  localparam int unsigned FieldW = $clog2(FIELD_COUNT + 1);

  logic              quote_q, quote_d;
  logic [FieldW-1:0] cur_q, cur_d;
  logic [6:0]        len_q, len_d;
  phase_e            phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [31:0]       mag_q, mag_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, res;
  logic              load;

  logic [FieldW+2:0] cur_ext;
  logic              fields_done, is_text, is_term, is_space, is_digit, is_delim;
  logic              empty;
  result_t           end_res;
  logic [35:0]       prod;
  logic [31:0]       limit;

  assign cur_ext     = (FieldW + 3)'(cur_q);
  assign fields_done = 32'(cur_q) >= 32'(FIELD_COUNT);
  assign is_text     = 32'(cur_q) < 32'(TEXT_FIELDS);
  assign is_term     = (in_byte_i == CH_NUL) || ((in_byte_i == CH_LF) && !quote_q);
  assign is_space    = in_byte_i inside {[8'd9:8'd13], CH_SPACE};
  assign is_digit    = in_byte_i inside {[CH_ZERO:CH_NINE]};
  assign is_delim    = (in_byte_i == CH_COMMA) || (in_byte_i == CH_COLON);
  assign empty       = (len_q == 7'd0);
  assign limit       = neg_q ? NEG_LIMIT : POS_LIMIT;
  assign prod        = {4'd0, mag_q} * 36'd10 + 36'(in_byte_i - CH_ZERO);

  always_comb begin
    end_res                = '0;
    end_res.kind           = KIND_FIELD_END;
    end_res.field_number   = cur_ext[2:0];
    end_res.field_empty    = empty;
    end_res.text_truncated = ovf_q;
    if (!is_text) begin
      if (empty) begin
        end_res.number = EMPTY_NUM;
      end else if (neg_q) begin
        end_res.number = 32'd0 - mag_q;
      end else begin
        end_res.number = mag_q;
      end
    end
  end

  always_comb begin
    quote_d = quote_q;
    cur_d   = cur_q;
    len_d   = len_q;
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    ovf_d   = ovf_q;
    load    = 1'b0;
    res     = '0;
    if (cmd_i.emit_rec) begin
      load     = 1'b1;
      res.kind = KIND_REC_END;
      res.last = 1'b1;
      quote_d  = 1'b0;
      cur_d    = '0;
      len_d    = '0;
      phase_d  = PH_SKIP;
      neg_d    = 1'b0;
      mag_d    = '0;
      ovf_d    = 1'b0;
    end else if (cmd_i.emit_end) begin
      load    = 1'b1;
      res     = end_res;
      cur_d   = cur_q + 1'b1;
      len_d   = '0;
      phase_d = PH_SKIP;
      neg_d   = 1'b0;
      mag_d   = '0;
      ovf_d   = 1'b0;
    end else if (cmd_i.take_byte && !is_term && !fields_done) begin
      if (in_byte_i == CH_QUOTE) begin
        quote_d = !quote_q;
      end else if (is_delim && !quote_q) begin
        load     = 1'b1;
        res      = end_res;
        res.last = 1'b1;
        cur_d    = cur_q + 1'b1;
        len_d    = '0;
        phase_d  = PH_SKIP;
        neg_d    = 1'b0;
        mag_d    = '0;
        ovf_d    = 1'b0;
      end else if (is_text) begin
        if (len_q < 7'(TEXT_LIMIT)) begin
          load             = 1'b1;
          res.kind         = KIND_TEXT;
          res.field_number = cur_ext[2:0];
          res.text_char    = in_byte_i;
          res.last         = 1'b1;
          len_d            = len_q + 7'd1;
        end else begin
          ovf_d = 1'b1;
        end
      end else begin
        if (len_q != LEN_MAX) begin
          len_d = len_q + 7'd1;
        end
        if ((phase_q == PH_SKIP) && is_space) begin
          phase_d = PH_SKIP;
        end else if ((phase_q == PH_SKIP) &&
                     ((in_byte_i == CH_PLUS) || (in_byte_i == CH_MINUS))) begin
          neg_d   = (in_byte_i == CH_MINUS);
          phase_d = PH_SIGN;
        end else if ((phase_q != PH_DONE) && is_digit) begin
          phase_d = PH_DIGITS;
          if (prod > 36'(limit)) begin
            mag_d = limit;
            ovf_d = 1'b1;
          end else begin
            mag_d = prod[31:0];
          end
        end else begin
          phase_d = PH_DONE;
        end
      end
    end
  end

  assign out_valid_d        = load || (out_valid_q && !out_ready_i);
  assign stat_o.out_free    = !out_valid_q || out_ready_i;
  assign stat_o.is_term     = is_term;
  assign stat_o.fields_done = fields_done;
  assign out_valid_o        = out_valid_q;
  assign out_o              = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q     <= 1'b0;
      cur_q       <= '0;
      len_q       <= '0;
      phase_q     <= PH_SKIP;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      quote_q     <= quote_d;
      cur_q       <= cur_d;
      len_q       <= len_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      mag_q       <= mag_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.take_byte, cmd_i.emit_end, cmd_i.emit_rec}))
    else $error("controller issued overlapping commands");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> stat_o.out_free)
    else $error("result register overwritten while occupied");

  a_rec_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_rec |=> (cur_q == '0) && !quote_q && (len_q == 7'd0))
    else $error("record end did not clear field state");

  a_rec_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind == KIND_REC_END)) |-> out_q.last)
    else $error("record end result without last");

  a_field_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_q) <= 32'(FIELD_COUNT))
    else $error("field counter ran past field count");

endmodule

[tb/sv/csv_record_field_parser_top_tb.sv]
// Self-checking testbench for csv_record_field_parser_top: a directed byte table, then random
// records and noise, with random idling on both channels and one long result hold-off.
// Depends on csvp_pkg, csvp_byte_if, csvp_result_if and the parser RTL.
module csv_record_field_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csvp_pkg::*;

  localparam int unsigned HALF_NS    = 5;
  localparam int unsigned TIMEOUT_NS = 10_000_000;
  localparam int unsigned NFIELD     = FieldCountDefault;
  localparam int unsigned NTEXT      = TextFieldsDefault;
  localparam int unsigned TLIMIT     = TextLimitDefault;
  localparam int unsigned RAND_ITEMS = 190;
  localparam int unsigned DRAIN_CYC  = 20;
  localparam int unsigned HOLD_CYC   = 400;
  localparam int unsigned HOLD_AFTER = 100;
  localparam logic [7:0]  WS_LO      = 8'd9;
  localparam logic [7:0]  WS_HI      = 8'd13;
  localparam result_t     NO_RES     = '0;
  localparam int unsigned NDIR       = 28;

  typedef struct {
    logic [7:0]  b;
    int unsigned reps;
    bit          typed;
    result_t     want;
  } stim_row_t;

  stim_row_t dir_tab [NDIR] = '{
    '{CH_NUL,   1,  1, '{KIND_FIELD_END, 3'd0, 8'd0, 32'd0, 1'b1, 1'b0, 1'b0}},
    '{"a",      1,  1, '{KIND_TEXT, 3'd0, "a", 32'd0, 1'b0, 1'b0, 1'b1}},
    '{CH_QUOTE, 1,  0, NO_RES},
    '{CH_COMMA, 1,  1, '{KIND_TEXT, 3'd0, CH_COMMA, 32'd0, 1'b0, 1'b0, 1'b1}},
    '{CH_LF,    1,  1, '{KIND_TEXT, 3'd0, CH_LF, 32'd0, 1'b0, 1'b0, 1'b1}},
    '{CH_QUOTE, 1,  0, NO_RES},
    '{CH_COLON, 1,  1, '{KIND_FIELD_END, 3'd0, 8'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
    '{"x",      55, 0, NO_RES},
    '{CH_COMMA, 1,  1, '{KIND_FIELD_END, 3'd1, 8'd0, 32'd0, 1'b0, 1'b1, 1'b1}},
    '{8'hFF,    1,  1, '{KIND_TEXT, 3'd2, 8'hFF, 32'd0, 1'b0, 1'b0, 1'b1}},
    '{CH_COMMA, 1,  0, NO_RES},
    '{CH_COMMA, 1,  1, '{KIND_FIELD_END, 3'd3, 8'd0, 32'd0, 1'b1, 1'b0, 1'b1}},
    '{WS_LO,    1,  0, NO_RES},
    '{CH_SPACE, 1,  0, NO_RES},
    '{CH_MINUS, 1,  0, NO_RES},
    '{"9",      12, 0, NO_RES},
    '{CH_COMMA, 1,  1, '{KIND_FIELD_END, 3'd4, 8'd0, NEG_LIMIT, 1'b0, 1'b1, 1'b1}},
    '{CH_COMMA, 1,  1, '{KIND_FIELD_END, 3'd5, 8'd0, EMPTY_NUM, 1'b1, 1'b0, 1'b1}},
    '{"7",      1,  0, NO_RES},
    '{"x",      1,  0, NO_RES},
    '{"3",      1,  0, NO_RES},
    '{CH_COMMA, 1,  1, '{KIND_FIELD_END, 3'd6, 8'd0, 32'd7, 1'b0, 1'b0, 1'b1}},
    '{"9",      12, 0, NO_RES},
    '{CH_COLON, 1,  1, '{KIND_FIELD_END, 3'd7, 8'd0, POS_LIMIT, 1'b0, 1'b1, 1'b1}},
    '{CH_QUOTE, 1,  0, NO_RES},
    '{CH_LF,    1,  1, '{KIND_REC_END, 3'd0, 8'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
    '{CH_QUOTE, 1,  0, NO_RES},
    '{CH_NUL,   1,  1, '{KIND_FIELD_END, 3'd0, 8'd0, 32'd0, 1'b1, 1'b0, 1'b0}}
  };

  string near_limit [4] = '{"2147483647", "2147483648", "2147483649", "999999999999"};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  csvp_byte_if   byte_if ();
  csvp_result_if res_if ();

  csv_record_field_parser_top uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (res_if)
  );

  always #(HALF_NS) clk_i = ~clk_i;

  logic       quoting   = 1'b0;
  int unsigned fld_idx  = 0;
  logic [6:0] fld_len   = '0;
  phase_e     num_phase = PH_SKIP;
  logic       num_neg   = 1'b0;
  logic [31:0] num_mag  = '0;
  logic       num_sat   = 1'b0;

  result_t     step_res [9];
  int unsigned step_n;
  result_t     pending_results [$];
  int unsigned error_cnt = 0;

  logic        tag_typed;
  result_t     tag_want;
  logic [7:0]  rand_bytes [$];
  bit          src_calm = 1'b0;

  function automatic result_t mk(logic [1:0] k, int unsigned f, logic [7:0] ch,
                                 logic [31:0] num, logic e, logic t);
    result_t r;
    r.kind           = k;
    r.field_number   = f[2:0];
    r.text_char      = ch;
    r.number         = num;
    r.field_empty    = e;
    r.text_truncated = t;
    r.last           = 1'b0;
    return r;
  endfunction

  function automatic void clear_field();
    fld_len   = '0;
    num_phase = PH_SKIP;
    num_neg   = 1'b0;
    num_mag   = '0;
    num_sat   = 1'b0;
  endfunction

  function automatic void close_field();
    logic [31:0] num;
    logic        e;
    e   = (fld_len == 0);
    num = '0;
    if (fld_idx >= NTEXT) begin
      num = e ? EMPTY_NUM : (num_neg ? 32'd0 - num_mag : num_mag);
    end
    step_res[step_n] = mk(KIND_FIELD_END, fld_idx, 8'd0, num, e, num_sat);
    step_n++;
    fld_idx++;
    clear_field();
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    logic [31:0] lim;
    logic [31:0] d;
    logic        ws;
    logic        dig;
    step_n = 0;
    ws  = (b == CH_SPACE) || (b >= WS_LO && b <= WS_HI);
    dig = (b >= CH_ZERO) && (b <= CH_NINE);
    if (b == CH_NUL || (b == CH_LF && !quoting)) begin
      while (fld_idx < NFIELD) close_field();
      step_res[step_n] = mk(KIND_REC_END, 0, 8'd0, 32'd0, 1'b0, 1'b0);
      step_n++;
      quoting = 1'b0;
      fld_idx = 0;
      clear_field();
    end else if (fld_idx < NFIELD) begin
      if (b == CH_QUOTE) begin
        quoting = !quoting;
      end else if ((b == CH_COMMA || b == CH_COLON) && !quoting) begin
        close_field();
      end else if (fld_idx < NTEXT) begin
        if (fld_len < TLIMIT) begin
          step_res[step_n] = mk(KIND_TEXT, fld_idx, b, 32'd0, 1'b0, 1'b0);
          step_n++;
          fld_len++;
        end else begin
          num_sat = 1'b1;
        end
      end else begin
        if (num_phase == PH_SKIP && (b == CH_PLUS || b == CH_MINUS)) begin
          num_neg   = (b == CH_MINUS);
          num_phase = PH_SIGN;
        end else if (num_phase != PH_DONE && dig) begin
          lim       = num_neg ? NEG_LIMIT : POS_LIMIT;
          d         = 32'(b - CH_ZERO);
          num_phase = PH_DIGITS;
          if (num_mag > (lim - d) / 10) begin
            num_mag = lim;
            num_sat = 1'b1;
          end else begin
            num_mag = num_mag * 10 + d;
          end
        end else if (!(num_phase == PH_SKIP && ws)) begin
          num_phase = PH_DONE;
        end
        if (fld_len < LEN_MAX) fld_len++;
      end
    end
    if (step_n > 0) step_res[step_n - 1].last = 1'b1;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("kind %0d field %0d char %02h number %08h empty %0d trunc %0d last %0d",
                     r.kind, r.field_number, r.text_char, r.number, r.field_empty,
                     r.text_truncated, r.last);
  endfunction

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_text(bit in_quotes);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_QUOTE ||
           (!in_quotes && (c == CH_COMMA || c == CH_COLON || c == CH_LF)));
    return c;
  endfunction

  function automatic void build_records();
    int unsigned nf;
    int unsigned len;
    int unsigned r;
    bit          inq;
    string       s;
    while (rand_bytes.size() < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(3, 20)) rand_bytes.push_back(8'($urandom_range(0, 255)));
        continue;
      end
      nf = (r < 20) ? $urandom_range(9, 11) : $urandom_range(0, 8);
      for (int f = 0; f < nf; f++) begin
        if (f != 0) rand_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_COLON : CH_COMMA);
        if (f < NTEXT) begin
          r   = $urandom_range(0, 99);
          len = (r < 4) ? $urandom_range(45, 60) :
                (r < 85) ? $urandom_range(0, 6) : $urandom_range(7, 15);
          inq = ($urandom_range(0, 3) == 0);
          if (inq) rand_bytes.push_back(CH_QUOTE);
          repeat (len) rand_bytes.push_back(pick_text(inq));
          if (inq && $urandom_range(0, 9) != 0) rand_bytes.push_back(CH_QUOTE);
        end else begin
          repeat ($urandom_range(0, 2)) begin
            rand_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE :
                                 8'($urandom_range(WS_LO, WS_HI)));
          end
          r = $urandom_range(0, 2);
          if (r == 1) rand_bytes.push_back(CH_PLUS);
          else if (r == 2) rand_bytes.push_back(CH_MINUS);
          r = $urandom_range(0, 99);
          if (r < 8) begin
            s = near_limit[$urandom_range(0, 3)];
            for (int i = 0; i < s.len(); i++) rand_bytes.push_back(8'(s[i]));
          end else begin
            repeat ((r < 15) ? $urandom_range(10, 12) : $urandom_range(0, 6)) begin
              rand_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
            end
          end
          if ($urandom_range(0, 4) == 0) rand_bytes.push_back(pick_text(1'b0));
        end
      end
      rand_bytes.push_back(($urandom_range(0, 6) == 0) ? CH_NUL : CH_LF);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) src_calm = !src_calm;
    gap = pick_gap(src_calm);
    if (gap != 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid   <= 1'b1;
    byte_if.in_byte <= b;
    tag_typed       <= typed;
    tag_want        <= want;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (byte_if.valid && byte_if.ready) begin
        parse_byte(byte_if.in_byte);
        if (tag_typed && step_n > 0) step_res[0] = tag_want;
        for (int i = 0; i < step_n; i++) pending_results.push_back(step_res[i]);
      end
      if (res_if.valid && res_if.ready) begin
        got.kind           = res_if.kind;
        got.field_number   = res_if.field_number;
        got.text_char      = res_if.text_char;
        got.number         = res_if.number;
        got.field_empty    = res_if.field_empty;
        got.text_truncated = res_if.text_truncated;
        got.last           = res_if.last;
        if (pending_results.size() == 0) begin
          if (error_cnt < 10) $display("%0t unexpected result: %s", $time, show(got));
          error_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.field_number !== want.field_number ||
              got.text_char !== want.text_char || got.number !== want.number ||
              got.field_empty !== want.field_empty ||
              got.text_truncated !== want.text_truncated || got.last !== want.last) begin
            if (error_cnt < 10) begin
              $display("%0t mismatch", $time);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
            error_cnt++;
          end
        end
      end
    end
  end

  initial begin : drain_results
    int unsigned hold;
    int unsigned taken;
    bit          squeezed;
    bit          snk_calm;
    hold     = 0;
    taken    = 0;
    squeezed = 1'b0;
    snk_calm = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 49) == 0) snk_calm = !snk_calm;
      if (res_if.valid && res_if.ready) taken++;
      // hold off once for a long stretch so the parser backs up into its input
      if (!squeezed && taken >= HOLD_AFTER) begin
        squeezed = 1'b1;
        hold     = HOLD_CYC;
      end else if (hold == 0) begin
        hold = pick_gap(snk_calm);
      end
      if (hold != 0) begin
        res_if.ready <= 1'b0;
        hold--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin : feed_bytes
    byte_if.valid   <= 1'b0;
    byte_if.in_byte <= '0;
    tag_typed       <= 1'b0;
    tag_want        <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_tab[i]) begin
      for (int k = 0; k < dir_tab[i].reps; k++) begin
        send_byte(dir_tab[i].b, dir_tab[i].typed && k == 0, dir_tab[i].want);
      end
    end
    build_records();
    foreach (rand_bytes[i]) send_byte(rand_bytes[i], 1'b0, NO_RES);
    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
